// ===== rtl/gwsp_pkg.sv =====
// shared types and constants for the graph walk step parser
package gwsp_pkg;

    // decimal token length limit: path mode raises the error flag on reaching it, walk mode on passing it
    localparam int unsigned DIGIT_LIMIT = 16;
    localparam int unsigned CNT_W       = $clog2(DIGIT_LIMIT + 1);
    localparam int unsigned ID_W        = 32;
    localparam int unsigned ACC_W       = ID_W + 4;

    // format_mode codes
    localparam logic MODE_WALK = 1'b0;
    localparam logic MODE_PATH = 1'b1;

    // characters with a meaning of their own
    localparam logic [7:0] CH_FWD_PREFIX = 8'h3E; // '>'
    localparam logic [7:0] CH_REV_PREFIX = 8'h3C; // '<'
    localparam logic [7:0] CH_FWD_SUFFIX = 8'h2B; // '+'
    localparam logic [7:0] CH_REV_SUFFIX = 8'h2D; // '-'
    localparam logic [7:0] CH_SEPARATOR  = 8'h2C; // ','
    localparam logic [7:0] CH_DIGIT_0    = 8'h30; // '0'
    localparam logic [7:0] CH_DIGIT_9    = 8'h39; // '9'

    // one input word
    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } char_word_t;

    // one result word
    typedef struct packed {
        logic            step_valid;
        logic [ID_W-1:0] vertex_id;
        logic            strand;
        logic [ID_W-1:0] step_index;
        logic            digit_error;
        logic            end_of_line;
    } step_word_t;

    // what the step unit hands to the output register
    typedef struct packed {
        logic       present;
        step_word_t word;
    } step_result_t;

endpackage

// ===== rtl/graph_walk_step_parser.sv =====
// top level of the graph walk step parser: input, config and output registers
//
// Parses one line of graph path text, one byte per word on the src channel
// (src_valid/src_ready, src_data.character and src_data.last_char), and
// returns oriented vertex steps on the dst channel (dst_valid/dst_ready).
// cfg_we/cfg_data set format_mode: 0 walk line ('>' or '<' prefix before
// the id), 1 path line (id closed by '+' or '-', ',' moves to the next step).
// Write the mode only while no word is in flight.
// A word yields a result when it completes a step or carries last_char;
// other words yield nothing. Results keep the input order.
// Path: an accepted word passes the input register, then the step unit's
// logic, and its result is held in the output register for dst.
// Throughput: one word per cycle while dst does not stall; the multiply-by-ten
// accumulate of the step unit is combinational between the input and output registers.
// When dst stalls, the output register holds its word and the input
// register takes one more word before src_ready drops.
// Reset clears the line state, the valid flags of both pipeline registers and the mode (walk).
// Line state returns to reset after every word that carries last_char.
module graph_walk_step_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_ready,
    input  gwsp_pkg::char_word_t  src_data,
    output logic                  dst_valid,
    input  logic                  dst_ready,
    output gwsp_pkg::step_word_t  dst_data,
    input  logic                  cfg_we,
    input  logic                  cfg_data
);
    import gwsp_pkg::*;

    logic         mode_reg;
    logic         in_valid_reg;
    char_word_t   in_word_reg;
    logic         out_valid_reg;
    step_word_t   out_word_reg;
    logic         advance;
    step_result_t result;

    // a held word moves on when the output register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || dst_ready);
    assign src_ready = !in_valid_reg || advance;
    assign dst_valid = out_valid_reg;
    assign dst_data  = out_word_reg;

    // format mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_WALK;
        else if (cfg_we)
            mode_reg <= cfg_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_ready)
            in_valid_reg <= src_valid;
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && src_ready)
            in_word_reg <= src_data;
    end

    // parse step
    gwsp_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .format_mode (mode_reg),
        .item        (in_word_reg),
        .result      (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= result.present;
        else if (dst_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.present)
            out_word_reg <= result.word;
    end

`ifndef SYNTHESIS
    // a completed step never goes out with the error flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.step_valid |-> !out_word_reg.digit_error)
        else $error("step emitted while digit error is set");

    // a word without a step carries zero step fields and the end-of-line flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.step_valid |->
            out_word_reg.vertex_id == '0 && out_word_reg.step_index == '0 &&
            !out_word_reg.strand && out_word_reg.end_of_line)
        else $error("empty result word has nonzero step fields");

    // src only stalls when both registers are full and dst is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !src_ready |-> in_valid_reg && out_valid_reg && !dst_ready)
        else $error("input stalled without a full pipeline");

    // a held input word that cannot move stays in place
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_word_reg))
        else $error("stalled input word lost or changed");
`endif

endmodule

// ===== rtl/gwsp_step.sv =====
// per-character parse step: line state registers and the next-state logic
module gwsp_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  format_mode,
    input  gwsp_pkg::char_word_t  item,
    output gwsp_pkg::step_result_t result
);
    import gwsp_pkg::*;

    logic [ID_W-1:0]  number_value_reg,   number_value_next;
    logic [CNT_W-1:0] digit_count_reg,    digit_count_next;
    logic             number_closed_reg,  number_closed_next;
    logic             pending_strand_reg, pending_strand_next;
    logic [ID_W-1:0]  step_counter_reg,   step_counter_next;
    logic             error_seen_reg,     error_seen_next;

    logic [7:0]       ch;
    logic             is_digit;
    logic [ACC_W-1:0] acc;
    logic [ID_W-1:0]  taken_value;
    logic             taken_closed;
    logic [ID_W-1:0]  bumped_counter;
    logic             emit;
    logic [ID_W-1:0]  emit_vid;
    logic             emit_strand;
    logic [ID_W-1:0]  emit_idx;

    assign ch       = item.character;
    assign is_digit = (ch >= CH_DIGIT_0) && (ch <= CH_DIGIT_9);

    // value times ten plus digit; saturation at the id maximum is applied in the token accumulation
    assign acc = ({{4{1'b0}}, number_value_reg} << 3)
               + ({{4{1'b0}}, number_value_reg} << 1)
               + {{(ACC_W - 4){1'b0}}, ch[3:0]};

    // token accumulation, frozen at the first non-digit
    always_comb
    begin
        taken_value  = number_value_reg;
        taken_closed = number_closed_reg;
        if (!number_closed_reg)
        begin
            if (is_digit)
                taken_value = (acc[ACC_W-1:ID_W] != '0) ? '1 : acc[ID_W-1:0];
            else
                taken_closed = 1'b1;
        end
    end

    // saturating step counter increment
    assign bumped_counter = (step_counter_reg != '1) ? step_counter_reg + 1'b1
                                                     : step_counter_reg;

    // next state and emitted step
    always_comb
    begin
        number_value_next   = number_value_reg;
        digit_count_next    = digit_count_reg;
        number_closed_next  = number_closed_reg;
        pending_strand_next = pending_strand_reg;
        step_counter_next   = step_counter_reg;
        error_seen_next     = error_seen_reg;
        emit                = 1'b0;
        emit_vid            = '0;
        emit_strand         = 1'b0;
        emit_idx            = '0;

        if (!error_seen_reg)
        begin
            if (format_mode == MODE_WALK)
            begin
                if (ch == CH_FWD_PREFIX || ch == CH_REV_PREFIX)
                begin
                    // a new prefix closes the previous step
                    if (step_counter_reg != '0)
                    begin
                        emit        = 1'b1;
                        emit_vid    = number_value_reg;
                        emit_strand = pending_strand_reg;
                        emit_idx    = step_counter_reg - 1'b1;
                    end
                    pending_strand_next = (ch == CH_REV_PREFIX);
                    step_counter_next   = bumped_counter;
                    number_value_next   = '0;
                    digit_count_next    = '0;
                    number_closed_next  = 1'b0;
                end
                else if (digit_count_reg >= CNT_W'(DIGIT_LIMIT))
                begin
                    error_seen_next = 1'b1;
                end
                else
                begin
                    digit_count_next   = digit_count_reg + 1'b1;
                    number_value_next  = taken_value;
                    number_closed_next = taken_closed;
                    // line end flushes a step whose token holds characters
                    if (item.last_char && step_counter_reg != '0)
                    begin
                        emit        = 1'b1;
                        emit_vid    = taken_value;
                        emit_strand = pending_strand_reg;
                        emit_idx    = step_counter_reg - 1'b1;
                    end
                end
            end
            else
            begin
                if (ch == CH_FWD_SUFFIX || ch == CH_REV_SUFFIX)
                begin
                    emit        = 1'b1;
                    emit_vid    = number_value_reg;
                    emit_strand = (ch == CH_REV_SUFFIX);
                    emit_idx    = step_counter_reg;
                end
                else if (ch == CH_SEPARATOR)
                begin
                    step_counter_next  = bumped_counter;
                    number_value_next  = '0;
                    digit_count_next   = '0;
                    number_closed_next = 1'b0;
                end
                else
                begin
                    digit_count_next   = digit_count_reg + 1'b1;
                    number_value_next  = taken_value;
                    number_closed_next = taken_closed;
                    if (digit_count_next >= CNT_W'(DIGIT_LIMIT))
                        error_seen_next = 1'b1;
                end
            end
        end

        result.present          = emit || item.last_char;
        result.word.step_valid  = emit;
        result.word.vertex_id   = emit_vid;
        result.word.strand      = emit_strand;
        result.word.step_index  = emit_idx;
        result.word.digit_error = error_seen_next;
        result.word.end_of_line = item.last_char;

        // line end returns the line state to reset
        if (item.last_char)
        begin
            number_value_next   = '0;
            digit_count_next    = '0;
            number_closed_next  = 1'b0;
            pending_strand_next = 1'b0;
            step_counter_next   = '0;
            error_seen_next     = 1'b0;
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_value_reg   <= '0;
            digit_count_reg    <= '0;
            number_closed_reg  <= 1'b0;
            pending_strand_reg <= 1'b0;
            step_counter_reg   <= '0;
            error_seen_reg     <= 1'b0;
        end
        else if (advance)
        begin
            number_value_reg   <= number_value_next;
            digit_count_reg    <= digit_count_next;
            number_closed_reg  <= number_closed_next;
            pending_strand_reg <= pending_strand_next;
            step_counter_reg   <= step_counter_next;
            error_seen_reg     <= error_seen_next;
        end
    end

endmodule
